// ----- hdl/lru_pr_pkg.sv -----
// shared constants and types for the lru page replacement block
// no dependencies; imported by lru_page_replacement and its testbench
package lru_pr_pkg;

	localparam int MAX_FRAMES = 16;
	localparam int PAGE_BITS  = 16;

	localparam int FIDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int FCNT_W = $clog2(MAX_FRAMES + 1);
	localparam int RANK_W = FIDX_W;
	localparam int CFG_W  = 5;
	localparam int TOT_W  = 32;

	// result word: is_hit, frame_index, evicted_valid, evicted_page, hits, misses
	localparam int RES_BITS = 1 + 4 + 1 + PAGE_BITS + TOT_W + TOT_W;
	localparam int OUT_W    = ((RES_BITS + 7) / 8) * 8;
	localparam int OUT_PAD  = OUT_W - RES_BITS;
	localparam int IN_W     = ((PAGE_BITS + 7) / 8) * 8;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// word index of the configuration register
	localparam logic REG_FRAMES_IN_USE = 1'b0;
	localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_TOUCH,
		ST_DONE
	} state_t;

endpackage

// ----- hdl/lru_page_replacement.sv -----
// lru page replacement: frame table, recency ranks and a shared scan sequencer
// depends on lru_pr_pkg
// after a word is accepted the frame scan walks the active frames from 0 (stops on the first
// match, n = active frames) and the recency update sweep visits all MAX_FRAMES frames, one frame
// per cycle through a single compare and increment unit; the result word is registered
// a new word is taken only in idle, after the previous result word has been loaded
// reset clears valid bits, ranks, fill count, totals and sets frames_in_use to 16;
// the page table itself is not cleared, so there is no clearing pass
module lru_page_replacement
	import lru_pr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // page_number
	output logic              m_tvalid,
	input  logic              m_tready,
	// is_hit, frame_index, evicted_valid, evicted_page, hits_so_far, misses_so_far, zero pad
	output logic [OUT_W-1:0]  m_tdata,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	state_t state_q, state_d;

	logic [CFG_W-1:0]     cfg_q;
	logic [FIDX_W-1:0]    idx_q;
	logic [FCNT_W-1:0]    filled_q;
	logic [TOT_W-1:0]     hits_q;
	logic [TOT_W-1:0]     misses_q;
	logic [MAX_FRAMES-1:0] valid_q;
	logic [RANK_W-1:0]    rank_q [MAX_FRAMES];
	logic [PAGE_BITS-1:0] fpage_q [MAX_FRAMES];
	logic                 m_tvalid_q;
	logic [OUT_W-1:0]     m_tdata_q;

	logic [PAGE_BITS-1:0] page_q;
	logic                 hit_q;
	logic [FIDX_W-1:0]    frame_q;
	logic                 ev_valid_q;
	logic [PAGE_BITS-1:0] ev_page_q;
	logic [FCNT_W-1:0]    limit_q;
	logic [FIDX_W-1:0]    best_idx_q;
	logic [RANK_W-1:0]    best_rank_q;
	logic [PAGE_BITS-1:0] best_page_q;

	logic [FCNT_W-1:0]    n_act;
	logic [PAGE_BITS-1:0] rd_page;
	logic [RANK_W-1:0]    rd_rank;
	logic                 rd_valid;
	logic                 hit_now;
	logic                 last_search;
	logic                 last_touch;
	logic                 take_new;
	logic [FIDX_W-1:0]    nb_idx;
	logic [RANK_W-1:0]    nb_rank;
	logic [PAGE_BITS-1:0] nb_page;
	logic                 fill;
	logic                 scan_end;
	logic                 miss_end;
	logic                 out_free;
	logic                 out_load;
	logic                 cfg_we;
	logic                 pg_we;
	logic [FIDX_W-1:0]    pg_waddr;

	assign pready   = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign cfg_we   = psel && penable && pwrite && pready
		&& (paddr[ADDR_W-1] == REG_FRAMES_IN_USE) && (paddr[ADDR_W-2:0] == '0);
	assign prdata   = (paddr[ADDR_W-1] == REG_FRAMES_IN_USE) ? DATA_W'(cfg_q) : '0;

	// zero acts as one, oversize saturates
	always_comb begin
		if (cfg_q == '0) begin
			n_act = FCNT_W'(1);
		end else if (32'(cfg_q) > MAX_FRAMES) begin
			n_act = FCNT_W'(MAX_FRAMES);
		end else begin
			n_act = FCNT_W'(cfg_q);
		end
	end

	// single read port of the frame table, shared by scan and sweep
	assign rd_page  = fpage_q[idx_q];
	assign rd_rank  = rank_q[idx_q];
	assign rd_valid = valid_q[idx_q];

	assign hit_now     = (state_q == ST_SEARCH) && rd_valid && (rd_page == page_q);
	assign last_search = (FCNT_W'(idx_q) == n_act - FCNT_W'(1));
	assign last_touch  = (idx_q == FIDX_W'(MAX_FRAMES - 1));
	assign scan_end    = (state_q == ST_SEARCH) && (hit_now || last_search);
	assign miss_end    = (state_q == ST_SEARCH) && !hit_now && last_search;
	assign fill        = (filled_q < n_act);

	// running victim: first frame with the largest rank
	assign take_new = (idx_q == '0) || (rd_rank > best_rank_q);
	assign nb_idx   = take_new ? idx_q   : best_idx_q;
	assign nb_rank  = take_new ? rd_rank : best_rank_q;
	assign nb_page  = take_new ? rd_page : best_page_q;

	assign pg_we    = miss_end;
	assign pg_waddr = fill ? filled_q[FIDX_W-1:0] : nb_idx;

	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = out_free
		&& (((state_q == ST_TOUCH) && last_touch) || (state_q == ST_DONE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (hit_now || last_search) state_d = ST_TOUCH;
			end
			ST_TOUCH: begin
				if (last_touch) state_d = out_free ? ST_IDLE : ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q      <= FRAMES_RESET;
			idx_q      <= '0;
			filled_q   <= '0;
			hits_q     <= '0;
			misses_q   <= '0;
			valid_q    <= '0;
			m_tvalid_q <= 1'b0;
			for (int g = 0; g < MAX_FRAMES; g++) begin
				rank_q[g] <= '0;
			end
		end else begin
			if (cfg_we) cfg_q <= pwdata[CFG_W-1:0];

			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
				end
				ST_SEARCH: begin
					idx_q <= scan_end ? '0 : idx_q + FIDX_W'(1);
					if (hit_now) begin
						if (hits_q != '1) hits_q <= hits_q + TOT_W'(1);
					end else if (last_search) begin
						if (misses_q != '1) misses_q <= misses_q + TOT_W'(1);
						if (fill) begin
							valid_q[filled_q[FIDX_W-1:0]] <= 1'b1;
							filled_q <= filled_q + FCNT_W'(1);
						end
					end
				end
				ST_TOUCH: begin
					// age frames more recent than the limit, chosen frame goes to rank 0
					idx_q <= idx_q + FIDX_W'(1);
					if (idx_q == frame_q) begin
						rank_q[idx_q] <= '0;
					end else if (rd_valid && (FCNT_W'(rd_rank) < limit_q)) begin
						rank_q[idx_q] <= rd_rank + RANK_W'(1);
					end
				end
				ST_DONE: begin
					idx_q <= '0;
				end
				default: idx_q <= '0;
			endcase

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// page table, undefined until written
	always_ff @(posedge clk) begin
		if (pg_we) fpage_q[pg_waddr] <= page_q;
	end

	// item payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) page_q <= s_tdata[PAGE_BITS-1:0];

		if (state_q == ST_SEARCH) begin
			best_idx_q  <= nb_idx;
			best_rank_q <= nb_rank;
			best_page_q <= nb_page;
			if (hit_now) begin
				hit_q      <= 1'b1;
				frame_q    <= idx_q;
				limit_q    <= FCNT_W'(rd_rank);
				ev_valid_q <= 1'b0;
				ev_page_q  <= '0;
			end else if (last_search) begin
				hit_q <= 1'b0;
				if (fill) begin
					frame_q    <= filled_q[FIDX_W-1:0];
					limit_q    <= FCNT_W'(MAX_FRAMES);
					ev_valid_q <= 1'b0;
					ev_page_q  <= '0;
				end else begin
					frame_q    <= nb_idx;
					limit_q    <= FCNT_W'(nb_rank);
					ev_valid_q <= 1'b1;
					ev_page_q  <= nb_page;
				end
			end
		end

		if (out_load) begin
			m_tdata_q <= {{OUT_PAD{1'b0}}, misses_q, hits_q, ev_page_q, ev_valid_q,
				4'(frame_q), hit_q};
		end
	end

	// filled frames are exactly the valid ones
	a_fill_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(filled_q))
		else $error("fill count and valid bits disagree");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(filled_q) <= MAX_FRAMES)
		else $error("fill count beyond frame table");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready && (state_q == ST_SEARCH))
		else $error("accepted word did not start a scan");

	a_one_count_per_item: assert property (@(posedge clk) disable iff (!arst_n)
		scan_end |=> ((hits_q != $past(hits_q)) || (misses_q != $past(misses_q))
			|| ($past(hits_q) == '1) || ($past(misses_q) == '1)))
		else $error("scan finished without a hit or miss count");

endmodule

// ----- tb/sv/lru_page_replacement_tb.sv -----
// self-checking testbench for lru_page_replacement: page stream in, hit/miss words out
// predicts every result word with its own frame table and recency ranks
// depends on lru_pr_pkg and lru_page_replacement
module lru_page_replacement_tb
	import lru_pr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// result word fields, last field first so the struct maps onto m_tdata from bit 0 up
	typedef struct packed {
		logic [TOT_W-1:0]     misses;
		logic [TOT_W-1:0]     hits;
		logic [PAGE_BITS-1:0] ev_page;
		logic                 ev_valid;
		logic [3:0]           frame;
		logic                 is_hit;
	} lru_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;     // page_number
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	// is_hit, frame_index, evicted_valid, evicted_page, hits_so_far, misses_so_far, zero pad
	logic [OUT_W-1:0]  m_tdata;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	lru_page_replacement u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow of the block's frame table
	logic [PAGE_BITS-1:0] frame_pg[MAX_FRAMES] = '{default: '0};
	bit                   frame_vld[MAX_FRAMES] = '{default: 1'b0};
	int                   frame_rank[MAX_FRAMES] = '{default: 0};
	int                   fill_cnt = 0;
	logic [TOT_W-1:0]     hit_cnt = '0;
	logic [TOT_W-1:0]     miss_cnt = '0;
	logic [CFG_W-1:0]     frames_cfg = FRAMES_RESET;

	lru_result_t pending_results[$];
	int mismatch_cnt = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req = 0;
	int hold_left = 0;

	logic [PAGE_BITS-1:0] page_pool[24];
	int pool_len = 1;

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("lru_page_replacement_tb failed");
		$finish;
	end

	// frame f becomes most recent; valid frames more recent than limit age by one
	function automatic void promote(int f, int limit);
		for (int g = 0; g < MAX_FRAMES; g++) begin
			if (g != f && frame_vld[g] && frame_rank[g] < limit)
				frame_rank[g]++;
		end
		frame_rank[f] = 0;
	endfunction

	function automatic lru_result_t lru_lookup(logic [PAGE_BITS-1:0] pg);
		lru_result_t res;
		int n;
		int f;
		int best;
		bit hit;
		res = '0;
		n = (frames_cfg == 0) ? 1 : ((frames_cfg > MAX_FRAMES) ? MAX_FRAMES : int'(frames_cfg));
		hit = 1'b0;
		f = 0;
		// lowest matching frame wins when a page sits in two frames
		for (int i = 0; i < n; i++) begin
			if (!hit && frame_vld[i] && frame_pg[i] == pg) begin
				hit = 1'b1;
				f = i;
			end
		end
		if (hit) begin
			promote(f, frame_rank[f]);
			if (hit_cnt != '1)
				hit_cnt++;
		end else begin
			if (fill_cnt < n) begin
				f = fill_cnt;
				frame_pg[f] = pg;
				frame_vld[f] = 1'b1;
				fill_cnt++;
				promote(f, MAX_FRAMES + 1);
			end else begin
				best = 0;
				for (int i = 1; i < n; i++) begin
					if (frame_rank[i] > frame_rank[best])
						best = i;
				end
				f = best;
				res.ev_valid = 1'b1;
				res.ev_page = frame_pg[f];
				frame_pg[f] = pg;
				promote(f, frame_rank[f]);
			end
			if (miss_cnt != '1)
				miss_cnt++;
		end
		res.is_hit = hit;
		res.frame = f[3:0];
		res.hits = hit_cnt;
		res.misses = miss_cnt;
		return res;
	endfunction

	function automatic void note_mismatch(string what, longint unsigned exp_v,
			longint unsigned got_v);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("mismatch on %s: expected %0h, got %0h", what, exp_v, got_v);
	endfunction

	task automatic check_result(input logic [OUT_W-1:0] word);
		lru_result_t got;
		lru_result_t exp_r;
		got = word[RES_BITS-1:0];
		if (pending_results.size() == 0) begin
			note_mismatch("unexpected word", 64'(0), word[63:0]);
		end else begin
			exp_r = pending_results.pop_front();
			if ($isunknown(word))
				note_mismatch("unknown bits in word", 64'(0), 64'(0));
			if (got.is_hit !== exp_r.is_hit)
				note_mismatch("is_hit", 64'(exp_r.is_hit), 64'(got.is_hit));
			if (got.frame !== exp_r.frame)
				note_mismatch("frame_index", 64'(exp_r.frame), 64'(got.frame));
			if (got.ev_valid !== exp_r.ev_valid)
				note_mismatch("evicted_valid", 64'(exp_r.ev_valid), 64'(got.ev_valid));
			if (got.ev_page !== exp_r.ev_page)
				note_mismatch("evicted_page", 64'(exp_r.ev_page), 64'(got.ev_page));
			if (got.hits !== exp_r.hits)
				note_mismatch("hits_so_far", 64'(exp_r.hits), 64'(got.hits));
			if (got.misses !== exp_r.misses)
				note_mismatch("misses_so_far", 64'(exp_r.misses), 64'(got.misses));
		end
	endtask

	// result side: check each word, then decide ready for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_page(input logic [PAGE_BITS-1:0] pg);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'(pg);
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(lru_lookup(pg));
	endtask

	task automatic drain_results();
		if (s_tvalid)
			s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// write frames_in_use with the block idle, then read it back
	task automatic write_frames(input logic [CFG_W-1:0] val);
		logic [DATA_W-1:0] rd;
		drain_results();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(REG_FRAMES_IN_USE) << 2;
		pwdata <= DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		frames_cfg = val;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd[CFG_W-1:0] !== val)
			note_mismatch("frames_in_use readback", 64'(val), 64'(rd[CFG_W-1:0]));
	endtask

	function automatic logic [PAGE_BITS-1:0] pick_page();
		if ($urandom_range(99) < 20)
			return PAGE_BITS'($urandom_range(0, 65535));
		return page_pool[$urandom_range(0, pool_len - 1)];
	endfunction

	function automatic void refill_pool(int len);
		pool_len = len;
		foreach (page_pool[i])
			page_pool[i] = PAGE_BITS'($urandom);
	endfunction

	// reset frame count: fill from frame 0, extreme pages, plain hits
	task automatic test_fill_and_hit();
		send_page(16'h0000);
		send_page(16'hFFFF);
		send_page(16'h5555);
		send_page(16'hAAAA);
		send_page(16'h0000);
		send_page(16'hFFFF);
		send_page(16'h1234);
	endtask

	// one frame, zero acting as one, lowering below the fill, duplicates, saturation
	task automatic test_frame_count_edges();
		write_frames(5'd1);
		send_page(16'h00FF);
		send_page(16'h00FF);
		write_frames(5'd0);
		send_page(16'hFF00);
		// 16'h5555 sits in frame 2, which is now outside the search
		write_frames(5'd2);
		send_page(16'h5555);
		write_frames(5'd31);
		send_page(16'h5555);
		send_page(16'hBEEF);
		write_frames(5'd17);
		send_page(16'h1234);
	endtask

	// receiver holds off long enough that the input side has to stall
	task automatic test_backpressure();
		write_frames(5'd4);
		refill_pool(6);
		send_idle_pct = 0;
		recv_idle_pct = 21;
		hold_req = 400;
		repeat (30)
			send_page(pick_page());
		drain_results();
	endtask

	task automatic test_random();
		logic [CFG_W-1:0] cfg_seq[12] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd4, 5'd9,
			5'd17, 5'd2, 5'd16, 5'd7, 5'd12, 5'd3};
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 21 : ((mode == 1) ? 63 : 0);
			recv_idle_pct = (mode == 0) ? 63 : ((mode == 1) ? 21 : 0);
			for (int ph = 0; ph < 4; ph++) begin
				write_frames(cfg_seq[mode * 4 + ph]);
				refill_pool($urandom_range(1, 24));
				repeat (65)
					send_page(pick_page());
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 21;
		recv_idle_pct = 63;
		test_fill_and_hit();
		test_frame_count_edges();
		test_backpressure();
		test_random();
		drain_results();
		repeat (40) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("lru_page_replacement_tb passed");
		else
			$display("lru_page_replacement_tb failed");
		$finish;
	end

endmodule
